>>> rtl/bts_pkg.sv
// bts_pkg: widths, register indexes and pipeline word types for the BM25 term scorer.
// No dependencies.
`timescale 1ns / 1ps
package bts_pkg;

    localparam int ID_W    = 32;
    localparam int TF_W    = 16;
    localparam int LEN_W   = 20;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;
    localparam int SCORE_W = 20;
    localparam int D_W     = 44;
    localparam int M_W     = 49;
    localparam int REM_W   = 69;
    localparam int Q_W     = SCORE_W + 1;
    localparam int CELLS   = Q_W;

    localparam logic [IDX_W-1:0] REG_IDF  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MEAN = 2'd1;

    localparam logic [CFG_W-1:0]   MEAN_RESET = 24'd256;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 20'hFFFFF;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic             dz;
        logic [M_W-1:0]   m;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } div_word_t;

endpackage

>>> rtl/bm25_term_score.sv
// bm25_term_score: BM25 term scorer top level; config registers, front pipeline, divider chain.
// Depends on bts_pkg, bts_front, bts_div_cell.
`timescale 1ns / 1ps
//  channel   dir  handshake          words
//  posting   in   start / busy       doc_id, term_freq, doc_len
//  result    out  done (one cycle)   out_doc_id, score
//  config    in   cfg_we             cfg_index, cfg_data
//
// One word accepted per cycle; busy stays low.
// Pipeline: 4 multiply stages, 21 divider cells, output register.
// Reset clears the valid chain and loads idf 0, mean 256.
// No stall: the result sits on the ports for one cycle only.
module bm25_term_score (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bts_pkg::ID_W-1:0]      doc_id,
    input  logic [bts_pkg::TF_W-1:0]      term_freq,
    input  logic [bts_pkg::LEN_W-1:0]     doc_len,
    input  logic                          cfg_we,
    input  logic [bts_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bts_pkg::CFG_W-1:0]     cfg_data,
    output logic                          done,
    output logic [bts_pkg::ID_W-1:0]      out_doc_id,
    output logic [bts_pkg::SCORE_W-1:0]   score
);
    import bts_pkg::*;

    logic [CFG_W-1:0]   idf_reg, mean_reg;
    logic               v_chain [0:CELLS];
    div_word_t          w_chain [0:CELLS];
    logic               done_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SCORE_W-1:0] score_reg, score_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idf_reg  <= '0;
            mean_reg <= MEAN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IDF:  idf_reg  <= cfg_data;
                REG_MEAN: mean_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign busy = 1'b0;

    bts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_id     (doc_id),
        .in_tf     (term_freq),
        .in_len    (doc_len),
        .idf       (idf_reg),
        .mean      (mean_reg),
        .out_valid (v_chain[0]),
        .out_word  (w_chain[0])
    );

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        bts_div_cell #(.K(CELLS - 1 - i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_chain[i]),
            .in_word   (w_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_word  (w_chain[i+1])
        );
    end

    always_comb
    begin
        if (w_chain[CELLS].dz)
        begin
            score_next = '0;
        end
        else if (w_chain[CELLS].q[Q_W-1])
        begin
            score_next = SCORE_MAX;
        end
        else
        begin
            score_next = w_chain[CELLS].q[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_chain[CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= w_chain[CELLS].id;
        score_reg <= score_next;
    end

    assign done       = done_reg;
    assign out_doc_id = id_reg;
    assign score      = score_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##26 done)
        else $error("result word missing after accepted posting");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 26))
        else $error("result word without accepted posting");
    a_zero_tf: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (term_freq == '0) |-> ##26 (score == '0))
        else $error("non-zero score for zero term frequency");
    a_id_pass: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##26 (out_doc_id == $past(doc_id, 26)))
        else $error("document id corrupted");
`endif

endmodule

>>> rtl/bts_front.sv
// bts_front: four-stage multiply pipeline forming numerator and divisor of the score.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [bts_pkg::ID_W-1:0]   in_id,
    input  logic [bts_pkg::TF_W-1:0]   in_tf,
    input  logic [bts_pkg::LEN_W-1:0]  in_len,
    input  logic [bts_pkg::CFG_W-1:0]  idf,
    input  logic [bts_pkg::CFG_W-1:0]  mean,
    output logic                       out_valid,
    output bts_pkg::div_word_t         out_word
);
    import bts_pkg::*;

    logic [3:0]       v_reg, v_next;
    logic [ID_W-1:0]  id1_reg, id2_reg, id3_reg;
    logic [39:0]      fm1_reg, fm1_next;
    logic [32:0]      dp1_reg, dp1_next;
    logic [D_W-1:0]   d2_reg, d2_next, a2_reg, a2_next, d3_reg;
    logic [45:0]      plo_reg, plo_next, phi_reg, phi_next;
    div_word_t        w4_reg, w4_next;

    always_comb
    begin
        v_next   = {v_reg[2:0], in_valid};
        fm1_next = 40'(in_tf) * 40'(mean);
        dp1_next = 33'(3) * 33'(mean) + (33'(in_len) << 11) + (33'(in_len) << 8);
        d2_next  = (D_W'(fm1_reg) << 3) + (D_W'(fm1_reg) << 1) + D_W'(dp1_reg);
        a2_next  = (D_W'(fm1_reg) << 3) + (D_W'(fm1_reg) << 1) + D_W'(fm1_reg);
        plo_next = 46'(a2_reg[21:0]) * 46'(idf);
        phi_next = 46'(a2_reg[43:22]) * 46'(idf);
        w4_next.id  = id3_reg;
        w4_next.dz  = (d3_reg == '0);
        w4_next.m   = M_W'(d3_reg) << 5;
        w4_next.rem = (REM_W'(phi_reg) << 22) + REM_W'(plo_reg) + (REM_W'(d3_reg) << 4);
        w4_next.q   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id1_reg <= in_id;
        fm1_reg <= fm1_next;
        dp1_reg <= dp1_next;
        id2_reg <= id1_reg;
        d2_reg  <= d2_next;
        a2_reg  <= a2_next;
        id3_reg <= id2_reg;
        d3_reg  <= d2_reg;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        w4_reg  <= w4_next;
    end

    assign out_valid = v_reg[3];
    assign out_word  = w4_reg;

endmodule

>>> rtl/bts_div_cell.sv
// bts_div_cell: one restoring-division cell, resolves one quotient bit per word.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_div_cell #(
    parameter int K = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bts_pkg::div_word_t  in_word,
    output logic                out_valid,
    output bts_pkg::div_word_t  out_word
);
    import bts_pkg::*;

    logic             valid_reg;
    div_word_t        word_reg, word_next;
    logic [REM_W-1:0] mk;
    logic             ge;

    always_comb
    begin
        mk        = REM_W'(in_word.m) << K;
        ge        = (in_word.rem >= mk);
        word_next = in_word;
        word_next.q = {in_word.q[Q_W-2:0], ge};
        if (ge)
        begin
            word_next.rem = in_word.rem - mk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && (in_word.rem < (mk << 1)) |=> (word_reg.rem < (REM_W'(word_reg.m) << K)))
        else $error("remainder not reduced below shifted divisor");
`endif

endmodule
